// File: hdl/scrt_pkg.sv
// Shared types and fixed constants for the slot capacity reservation table.
// Used by the front end, command queue, back end and top level; depends on nothing.
package scrt_pkg;

   // Field widths fixed by the request and result formats.
   localparam int RESOURCE_ID_BITS = 6;
   localparam int TIME_BITS        = 12;
   localparam int COUNT_BITS       = 8;
   localparam int ID_SPAN          = 1 << RESOURCE_ID_BITS;

   // Resource kinds.
   localparam logic [1:0] KIND_SECTOR    = 2'd0;
   localparam logic [1:0] KIND_ARRIVAL   = 2'd1;
   localparam logic [1:0] KIND_DEPARTURE = 2'd2;

   // Actions.
   localparam logic ACT_QUERY   = 1'b0;
   localparam logic ACT_RESERVE = 1'b1;

   // Result status codes.
   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_RANGE  = 2'd1;
   localparam logic [1:0] STATUS_REFUSE = 2'd2;

   // Queue depths between the parts.
   localparam int CMD_QUEUE_DEPTH = 2;
   localparam int CMD_PTR_BITS    = 1;
   localparam int RSP_QUEUE_DEPTH = 2;
   localparam int RSP_PTR_BITS    = 1;

   typedef struct packed {
      logic                        action;
      logic [1:0]                  resource_kind;
      logic [RESOURCE_ID_BITS-1:0] resource_id;
      logic [TIME_BITS-1:0]        time_req;
      logic [COUNT_BITS-1:0]       capacity;
   } req_type;

   typedef struct packed {
      logic                  at_capacity;
      logic [COUNT_BITS-1:0] remaining;
      logic [1:0]            status;
   } rsp_type;

   // Classified command: slot_idx is the sector time or the airport bin.
   typedef struct packed {
      logic                        range_err;
      logic                        action;
      logic [1:0]                  resource_kind;
      logic [RESOURCE_ID_BITS-1:0] resource_id;
      logic [TIME_BITS-1:0]        slot_idx;
      logic [COUNT_BITS-1:0]       capacity;
   } cmd_type;

   typedef struct packed {
      logic clearing;
      logic busy;
   } back_status_type;

endpackage

// File: hdl/scrt_front.sv
// Front end: classifies a request word, maps airport times to bins, flags range errors.
// Depends on scrt_pkg.
module scrt_front #(
   parameter int SECTOR_COUNT  = 64,
   parameter int AIRPORT_COUNT = 64,
   parameter int TIME_SLOTS    = 256,
   parameter int BIN_COUNT     = 32,
   parameter int BIN_WIDTH     = 15
) (
   input  logic                     push,
   input  scrt_pkg::req_type        req_word,
   output logic                     full,
   input  logic                     cmd_full,
   input  scrt_pkg::back_status_type back_status,
   output logic                     cmd_push,
   output scrt_pkg::cmd_type        cmd_word
);

   // Bin = floor(x / BIN_WIDTH) as x * ceil(2^24 / BIN_WIDTH) >> 24; exact for 12-bit x.
   localparam int         RECIP_SHIFT = 24;
   localparam int         RECIP_BITS  = RECIP_SHIFT + 1;
   localparam int         PROD_BITS   = RECIP_BITS + scrt_pkg::TIME_BITS;
   localparam logic [RECIP_BITS-1:0] RECIP =
      RECIP_BITS'(((1 << RECIP_SHIFT) + BIN_WIDTH - 1) / BIN_WIDTH);

   logic [scrt_pkg::TIME_BITS-1:0] bin_base;
   logic [PROD_BITS-1:0]           bin_prod;
   logic [scrt_pkg::TIME_BITS-1:0] bin_idx;
   logic                           sector_ok;
   logic                           airport_ok;

   assign full     = cmd_full | back_status.clearing;
   assign cmd_push = push & ~full;

   always_comb begin
      bin_base = (req_word.time_req == '0) ? '0 : req_word.time_req - 12'd1;
      bin_prod = PROD_BITS'(bin_base) * PROD_BITS'(RECIP);
      bin_idx  = bin_prod[RECIP_SHIFT +: scrt_pkg::TIME_BITS];

      sector_ok  = (11'(req_word.resource_id) < 11'(SECTOR_COUNT)) &&
                   (13'(req_word.time_req) < 13'(TIME_SLOTS));
      airport_ok = (11'(req_word.resource_id) < 11'(AIRPORT_COUNT)) &&
                   (13'(bin_idx) < 13'(BIN_COUNT));

      cmd_word.action        = req_word.action;
      cmd_word.resource_kind = req_word.resource_kind;
      cmd_word.resource_id   = req_word.resource_id;
      cmd_word.capacity      = req_word.capacity;
      case (req_word.resource_kind)
         scrt_pkg::KIND_SECTOR: begin
            cmd_word.range_err = ~sector_ok;
            cmd_word.slot_idx  = req_word.time_req;
         end
         scrt_pkg::KIND_ARRIVAL, scrt_pkg::KIND_DEPARTURE: begin
            cmd_word.range_err = ~airport_ok;
            cmd_word.slot_idx  = bin_idx;
         end
         default: begin
            cmd_word.range_err = 1'b1;
            cmd_word.slot_idx  = req_word.time_req;
         end
      endcase
   end

endmodule

// File: hdl/scrt_cmd_queue.sv
// Short command queue between the front end and the back end.
// Depends on scrt_pkg.
module scrt_cmd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  scrt_pkg::cmd_type word_in,
   output logic              full,
   input  logic              pop,
   output logic              valid,
   output scrt_pkg::cmd_type word_out
);

   localparam int CNT_BITS = scrt_pkg::CMD_PTR_BITS + 1;

   scrt_pkg::cmd_type                 entry_ff [scrt_pkg::CMD_QUEUE_DEPTH];
   logic [scrt_pkg::CMD_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [scrt_pkg::CMD_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]               count_ff, count_in;
   logic                              do_push, do_pop;

   assign full     = (count_ff == CNT_BITS'(scrt_pkg::CMD_QUEUE_DEPTH));
   assign valid    = (count_ff != '0);
   assign word_out = entry_ff[rd_ptr_ff];
   assign do_push  = push & ~full;
   assign do_pop   = pop & valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + CNT_BITS'(do_push) - CNT_BITS'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= word_in;
      end
   end

endmodule

// File: hdl/scrt_back.sv
// Back end: use-count and limit memories, read-modify-write per command, result queue.
// Depends on scrt_pkg.
module scrt_back #(
   parameter int SECTOR_COUNT  = 64,
   parameter int AIRPORT_COUNT = 64,
   parameter int TIME_SLOTS    = 256,
   parameter int BIN_COUNT     = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      cmd_valid,
   input  scrt_pkg::cmd_type         cmd_word,
   output logic                      cmd_pop,
   output scrt_pkg::back_status_type back_status,
   input  logic                      pop,
   output logic                      empty,
   output scrt_pkg::rsp_type         rsp_word
);

   localparam int SEC_ROWS  = (SECTOR_COUNT < scrt_pkg::ID_SPAN) ? SECTOR_COUNT
                                                                : scrt_pkg::ID_SPAN;
   localparam int APT_ROWS  = (AIRPORT_COUNT < scrt_pkg::ID_SPAN) ? AIRPORT_COUNT
                                                                 : scrt_pkg::ID_SPAN;
   localparam int SEC_RBITS = (SEC_ROWS > 1) ? $clog2(SEC_ROWS) : 1;
   localparam int APT_RBITS = (APT_ROWS > 1) ? $clog2(APT_ROWS) : 1;
   localparam int SLOT_BITS = $clog2(TIME_SLOTS);
   localparam int BIN_BITS  = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
   localparam int SEC_ABITS = SEC_RBITS + SLOT_BITS;
   localparam int APT_ABITS = APT_RBITS + BIN_BITS;
   localparam int CLR_BITS  = (SEC_ABITS > APT_ABITS) ? SEC_ABITS : APT_ABITS;
   localparam int CB        = scrt_pkg::COUNT_BITS;
   localparam int RCNT_BITS = scrt_pkg::RSP_PTR_BITS + 1;

   // Storage.
   logic [CB-1:0]        sec_used_mem [1 << SEC_ABITS];
   logic [CB-1:0]        arr_used_mem [1 << APT_ABITS];
   logic [CB-1:0]        dep_used_mem [1 << APT_ABITS];
   logic [CB-1:0]        sec_lim_mem  [1 << SEC_RBITS];
   logic [CB-1:0]        arr_lim_mem  [1 << APT_RBITS];
   logic [CB-1:0]        dep_lim_mem  [1 << APT_RBITS];
   logic [(1 << SEC_RBITS)-1:0] sec_seen_ff;
   logic [(1 << APT_RBITS)-1:0] arr_seen_ff;
   logic [(1 << APT_RBITS)-1:0] dep_seen_ff;

   // Registered read data.
   logic [CB-1:0] rd_sec_used_ff, rd_arr_used_ff, rd_dep_used_ff;
   logic [CB-1:0] rd_sec_lim_ff, rd_arr_lim_ff, rd_dep_lim_ff;

   // Control.
   logic                clear_ff, clear_in;
   logic [CLR_BITS-1:0] clr_idx_ff, clr_idx_in;
   logic                busy_ff, busy_in;
   scrt_pkg::cmd_type   cur_ff;

   // Result queue.
   scrt_pkg::rsp_type                 rsp_buf_ff [scrt_pkg::RSP_QUEUE_DEPTH];
   logic [scrt_pkg::RSP_PTR_BITS-1:0] rsp_wr_ff, rsp_wr_in, rsp_rd_ff, rsp_rd_in;
   logic [RCNT_BITS-1:0]              rsp_cnt_ff, rsp_cnt_in;
   logic                              rsp_pop;

   // Addresses.
   logic [SEC_ABITS-1:0] head_sec_addr, cur_sec_addr, clr_sec_addr;
   logic [APT_ABITS-1:0] head_apt_addr, cur_apt_addr, clr_apt_addr;
   logic [SEC_RBITS-1:0] head_sec_row, cur_sec_row;
   logic [APT_RBITS-1:0] head_apt_row, cur_apt_row;
   logic                 clr_sec_en, clr_apt_en;

   // Execute stage.
   logic          seen;
   logic [CB-1:0] lim_rd, used_rd, limit, room;
   logic          no_room;
   logic          take_unit;
   logic          latch_limit;
   scrt_pkg::rsp_type result;
   logic          wr_sec, wr_arr, wr_dep;
   logic          lat_sec, lat_arr, lat_dep;

   assign head_sec_row  = cmd_word.resource_id[SEC_RBITS-1:0];
   assign head_apt_row  = cmd_word.resource_id[APT_RBITS-1:0];
   assign head_sec_addr = {head_sec_row, cmd_word.slot_idx[SLOT_BITS-1:0]};
   assign head_apt_addr = {head_apt_row, cmd_word.slot_idx[BIN_BITS-1:0]};
   assign cur_sec_row   = cur_ff.resource_id[SEC_RBITS-1:0];
   assign cur_apt_row   = cur_ff.resource_id[APT_RBITS-1:0];
   assign cur_sec_addr  = {cur_sec_row, cur_ff.slot_idx[SLOT_BITS-1:0]};
   assign cur_apt_addr  = {cur_apt_row, cur_ff.slot_idx[BIN_BITS-1:0]};
   assign clr_sec_addr  = clr_idx_ff[SEC_ABITS-1:0];
   assign clr_apt_addr  = clr_idx_ff[APT_ABITS-1:0];
   assign clr_sec_en    = clear_ff && ((clr_idx_ff >> SEC_ABITS) == '0);
   assign clr_apt_en    = clear_ff && ((clr_idx_ff >> APT_ABITS) == '0);

   // Issue one command at a time; result slot is guaranteed before the read.
   assign cmd_pop = cmd_valid & ~clear_ff & ~busy_ff &
                    (rsp_cnt_ff != RCNT_BITS'(scrt_pkg::RSP_QUEUE_DEPTH));

   assign back_status.clearing = clear_ff;
   assign back_status.busy     = busy_ff;

   always_comb begin
      case (cur_ff.resource_kind)
         scrt_pkg::KIND_SECTOR: begin
            seen    = sec_seen_ff[cur_sec_row];
            lim_rd  = rd_sec_lim_ff;
            used_rd = rd_sec_used_ff;
         end
         scrt_pkg::KIND_ARRIVAL: begin
            seen    = arr_seen_ff[cur_apt_row];
            lim_rd  = rd_arr_lim_ff;
            used_rd = rd_arr_used_ff;
         end
         default: begin
            seen    = dep_seen_ff[cur_apt_row];
            lim_rd  = rd_dep_lim_ff;
            used_rd = rd_dep_used_ff;
         end
      endcase

      limit     = seen ? lim_rd : cur_ff.capacity;
      room      = limit - used_rd;
      no_room   = (room == '0);
      take_unit = busy_ff && !cur_ff.range_err && !no_room &&
                  (cur_ff.action == scrt_pkg::ACT_RESERVE);
      latch_limit = busy_ff && !cur_ff.range_err && !seen;

      if (cur_ff.range_err) begin
         result.at_capacity = 1'b0;
         result.remaining   = '0;
         result.status      = scrt_pkg::STATUS_RANGE;
      end else if (no_room) begin
         result.at_capacity = 1'b1;
         result.remaining   = '0;
         result.status      = (cur_ff.action == scrt_pkg::ACT_RESERVE) ?
                              scrt_pkg::STATUS_REFUSE : scrt_pkg::STATUS_OK;
      end else begin
         result.at_capacity = 1'b0;
         result.remaining   = take_unit ? room - 8'd1 : room;
         result.status      = scrt_pkg::STATUS_OK;
      end

      wr_sec  = take_unit && (cur_ff.resource_kind == scrt_pkg::KIND_SECTOR);
      wr_arr  = take_unit && (cur_ff.resource_kind == scrt_pkg::KIND_ARRIVAL);
      wr_dep  = take_unit && (cur_ff.resource_kind == scrt_pkg::KIND_DEPARTURE);
      lat_sec = latch_limit && (cur_ff.resource_kind == scrt_pkg::KIND_SECTOR);
      lat_arr = latch_limit && (cur_ff.resource_kind == scrt_pkg::KIND_ARRIVAL);
      lat_dep = latch_limit && (cur_ff.resource_kind == scrt_pkg::KIND_DEPARTURE);
   end

   // Control next state.
   assign rsp_pop = pop & ~empty;

   always_comb begin
      clear_in   = clear_ff && !(&clr_idx_ff);
      clr_idx_in = clear_ff ? clr_idx_ff + 1'b1 : clr_idx_ff;
      busy_in    = cmd_pop;
      rsp_wr_in  = busy_ff ? rsp_wr_ff + 1'b1 : rsp_wr_ff;
      rsp_rd_in  = rsp_pop ? rsp_rd_ff + 1'b1 : rsp_rd_ff;
      rsp_cnt_in = rsp_cnt_ff + RCNT_BITS'(busy_ff) - RCNT_BITS'(rsp_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff    <= 1'b1;
         clr_idx_ff  <= '0;
         busy_ff     <= 1'b0;
         rsp_wr_ff   <= '0;
         rsp_rd_ff   <= '0;
         rsp_cnt_ff  <= '0;
         sec_seen_ff <= '0;
         arr_seen_ff <= '0;
         dep_seen_ff <= '0;
      end else begin
         clear_ff   <= clear_in;
         clr_idx_ff <= clr_idx_in;
         busy_ff    <= busy_in;
         rsp_wr_ff  <= rsp_wr_in;
         rsp_rd_ff  <= rsp_rd_in;
         rsp_cnt_ff <= rsp_cnt_in;
         if (lat_sec) begin
            sec_seen_ff[cur_sec_row] <= 1'b1;
         end
         if (lat_arr) begin
            arr_seen_ff[cur_apt_row] <= 1'b1;
         end
         if (lat_dep) begin
            dep_seen_ff[cur_apt_row] <= 1'b1;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         cur_ff <= cmd_word;
      end
      if (busy_ff) begin
         rsp_buf_ff[rsp_wr_ff] <= result;
      end
   end

   // Use-count memories: clearing sweep, else read-modify-write write-back.
   always_ff @(posedge clock) begin
      if (clr_sec_en) begin
         sec_used_mem[clr_sec_addr] <= '0;
      end else if (wr_sec) begin
         sec_used_mem[cur_sec_addr] <= used_rd + 8'd1;
      end
      rd_sec_used_ff <= sec_used_mem[head_sec_addr];
   end

   always_ff @(posedge clock) begin
      if (clr_apt_en) begin
         arr_used_mem[clr_apt_addr] <= '0;
      end else if (wr_arr) begin
         arr_used_mem[cur_apt_addr] <= used_rd + 8'd1;
      end
      rd_arr_used_ff <= arr_used_mem[head_apt_addr];
   end

   always_ff @(posedge clock) begin
      if (clr_apt_en) begin
         dep_used_mem[clr_apt_addr] <= '0;
      end else if (wr_dep) begin
         dep_used_mem[cur_apt_addr] <= used_rd + 8'd1;
      end
      rd_dep_used_ff <= dep_used_mem[head_apt_addr];
   end

   // Limit memories: written once per resource, guarded by the seen bits.
   always_ff @(posedge clock) begin
      if (lat_sec) begin
         sec_lim_mem[cur_sec_row] <= cur_ff.capacity;
      end
      rd_sec_lim_ff <= sec_lim_mem[head_sec_row];
   end

   always_ff @(posedge clock) begin
      if (lat_arr) begin
         arr_lim_mem[cur_apt_row] <= cur_ff.capacity;
      end
      rd_arr_lim_ff <= arr_lim_mem[head_apt_row];
   end

   always_ff @(posedge clock) begin
      if (lat_dep) begin
         dep_lim_mem[cur_apt_row] <= cur_ff.capacity;
      end
      rd_dep_lim_ff <= dep_lim_mem[head_apt_row];
   end

   assign empty    = (rsp_cnt_ff == '0);
   assign rsp_word = rsp_buf_ff[rsp_rd_ff];

endmodule

// File: hdl/slot_capacity_reservation_table_top.sv
// Top level of the slot capacity reservation table.
// Depends on scrt_pkg, scrt_front, scrt_cmd_queue and scrt_back.

// Each request word names a table (sector slot, airport arrival bin or airport
// departure bin), a resource, a time and a capacity, and either queries the
// slot or reserves one unit in it; every request returns exactly one result
// word, in order. After reset the block runs a clearing pass over the use
// counters and holds full high until it has swept all 2**max(S, A) counter
// addresses, where S is clog2(min(SECTOR_COUNT, 64)) + clog2(TIME_SLOTS)
// and A is clog2(min(AIRPORT_COUNT, 64)) + clog2(BIN_COUNT). After that a
// request is executed in the back end as a memory read, then compute and
// write-back of the use counter; the back end takes no new command until
// the current one is written back. A two-entry command queue decouples the
// classifier from the back end, and a two-entry result queue lets new
// requests be taken while a result waits to be popped.
module slot_capacity_reservation_table_top #(
   parameter int SECTOR_COUNT  = 64,
   parameter int AIRPORT_COUNT = 64,
   parameter int TIME_SLOTS    = 256,
   parameter int BIN_COUNT     = 32,
   parameter int BIN_WIDTH     = 15
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  scrt_pkg::req_type req_word,
   input  logic              pop,
   output logic              empty,
   output scrt_pkg::rsp_type rsp_word
);

   scrt_pkg::cmd_type         front_cmd;
   scrt_pkg::cmd_type         head_cmd;
   scrt_pkg::back_status_type back_status;
   logic                      cmd_push;
   logic                      cmd_full;
   logic                      cmd_valid;
   logic                      cmd_pop;

   // Classify and bin the incoming word; hold it off while clearing.
   scrt_front #(
      .SECTOR_COUNT (SECTOR_COUNT),
      .AIRPORT_COUNT(AIRPORT_COUNT),
      .TIME_SLOTS   (TIME_SLOTS),
      .BIN_COUNT    (BIN_COUNT),
      .BIN_WIDTH    (BIN_WIDTH)
   ) u_front (
      .push       (push),
      .req_word   (req_word),
      .full       (full),
      .cmd_full   (cmd_full),
      .back_status(back_status),
      .cmd_push   (cmd_push),
      .cmd_word   (front_cmd)
   );

   // Buffer classified commands so each side can stall on its own.
   scrt_cmd_queue u_cmd_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (cmd_push),
      .word_in (front_cmd),
      .full    (cmd_full),
      .pop     (cmd_pop),
      .valid   (cmd_valid),
      .word_out(head_cmd)
   );

   // Execute against the use counters and limits; queue results.
   scrt_back #(
      .SECTOR_COUNT (SECTOR_COUNT),
      .AIRPORT_COUNT(AIRPORT_COUNT),
      .TIME_SLOTS   (TIME_SLOTS),
      .BIN_COUNT    (BIN_COUNT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd_word   (head_cmd),
      .cmd_pop    (cmd_pop),
      .back_status(back_status),
      .pop        (pop),
      .empty      (empty),
      .rsp_word   (rsp_word)
   );

   // No request enters while the counters are being cleared.
   assert property (@(posedge clock) disable iff (reset)
      back_status.clearing |-> full)
      else $error("request path open during clearing pass");

   // A command taken by the back end is executed in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      cmd_pop |=> back_status.busy)
      else $error("issued command not executed");

   // The back end never works while clearing.
   assert property (@(posedge clock) disable iff (reset)
      back_status.busy |-> !back_status.clearing)
      else $error("command executed during clearing pass");

   // Every executed command leaves a result waiting.
   assert property (@(posedge clock) disable iff (reset)
      back_status.busy |=> !empty)
      else $error("executed command produced no result");

endmodule

// File: dv/slot_capacity_reservation_table_top_tb.sv
// Self-checking testbench for slot_capacity_reservation_table_top.
// Depends on scrt_pkg and the block's RTL; carries its own booking predictor.
module slot_capacity_reservation_table_top_tb;

   // Table geometry, matching the block's default parameters.
   localparam int N_SECTORS    = 64;
   localparam int N_AIRPORTS   = 64;
   localparam int N_TIME_SLOTS = 256;
   localparam int N_BINS       = 32;
   localparam int BIN_SPAN     = 15;
   localparam int TABLE_DEPTH  = N_SECTORS * N_TIME_SLOTS;
   localparam int REQ_BITS     = $bits(scrt_pkg::req_type);

   // The one resource kind code that names no table.
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   // One row of the directed plan: a request word and, where it is obvious,
   // the result word typed in by hand.
   typedef struct {
      scrt_pkg::req_type word;
      bit                typed;
      scrt_pkg::rsp_type want;
   } stim_row_type;

   logic              clock    = 1'b0;
   logic              reset    = 1'b1;
   logic              push     = 1'b0;
   logic              pop      = 1'b0;
   scrt_pkg::req_type req_word = '0;
   logic              full;
   logic              empty;
   scrt_pkg::rsp_type rsp_word;

   // Side info that travels with the word on req_word.
   bit                req_typed = 1'b0;
   scrt_pkg::rsp_type req_want  = '0;

   // Predictor state: use counters per table and slot, latched capacity per
   // table and resource. Table index is the resource kind.
   bit [7:0] slot_use      [3][TABLE_DEPTH];
   bit [7:0] slot_limit    [3][N_SECTORS];
   bit       limit_latched [3][N_SECTORS];

   scrt_pkg::rsp_type answers_due [$];
   int                errors    = 0;
   bit                idle_on   = 1'b1;
   int                pop_hold  = 0;
   int                hot_base  = 0;

   slot_capacity_reservation_table_top dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_word (req_word),
      .pop      (pop),
      .empty    (empty),
      .rsp_word (rsp_word)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Work out the result of one accepted word and advance the tables.
   function automatic scrt_pkg::rsp_type book_slot(scrt_pkg::req_type w);
      scrt_pkg::rsp_type r;
      int                k;
      int                t;
      int                bin;
      int                slot_idx;
      logic [7:0]        room;
      r.at_capacity = 1'b0;
      r.remaining   = '0;
      r.status      = scrt_pkg::STATUS_RANGE;
      k = int'(w.resource_kind);
      t = int'(w.time_req);
      if (w.resource_kind == scrt_pkg::KIND_SECTOR) begin
         if (w.resource_id >= N_SECTORS || t >= N_TIME_SLOTS) return r;
         slot_idx = w.resource_id * N_TIME_SLOTS + t;
      end else if (w.resource_kind == scrt_pkg::KIND_ARRIVAL ||
                   w.resource_kind == scrt_pkg::KIND_DEPARTURE) begin
         // Time 0 shares bin 0 with times 1 through BIN_SPAN.
         bin = (t == 0) ? 0 : (t - 1) / BIN_SPAN;
         if (w.resource_id >= N_AIRPORTS || bin >= N_BINS) return r;
         slot_idx = w.resource_id * N_BINS + bin;
      end else begin
         return r;
      end
      // Latch the capacity on the first in-range touch, reserve or not.
      if (!limit_latched[k][w.resource_id]) begin
         slot_limit[k][w.resource_id]    = w.capacity;
         limit_latched[k][w.resource_id] = 1'b1;
      end
      room = slot_limit[k][w.resource_id] - slot_use[k][slot_idx];
      if (room == 8'd0) begin
         r.at_capacity = 1'b1;
         r.status      = (w.action == scrt_pkg::ACT_RESERVE) ? scrt_pkg::STATUS_REFUSE
                                                             : scrt_pkg::STATUS_OK;
         return r;
      end
      if (w.action == scrt_pkg::ACT_RESERVE) begin
         slot_use[k][slot_idx] = slot_use[k][slot_idx] + 8'd1;
         room = room - 8'd1;
      end
      r.remaining = room;
      r.status    = scrt_pkg::STATUS_OK;
      return r;
   endfunction

   function automatic stim_row_type entry(logic act, logic [1:0] kind, int id, int t,
                                          int cap, bit typed = 1'b0, logic at = 1'b0,
                                          int rem = 0,
                                          logic [1:0] st = scrt_pkg::STATUS_OK);
      stim_row_type s;
      s.word.action        = act;
      s.word.resource_kind = kind;
      s.word.resource_id   = 6'(id);
      s.word.time_req      = 12'(t);
      s.word.capacity      = 8'(cap);
      s.typed              = typed;
      s.want.at_capacity   = at;
      s.want.remaining     = 8'(rem);
      s.want.status        = st;
      return s;
   endfunction

   // Mostly well-formed traffic aimed at a few hot resources and slots, so
   // slots fill up and refusals show; one word in eight is raw noise that
   // hits the unused kind and times past the tables.
   function automatic scrt_pkg::req_type random_word();
      scrt_pkg::req_type w;
      if ($urandom_range(0, 7) == 0) begin
         w = REQ_BITS'($urandom);
         return w;
      end
      w.action        = ($urandom_range(0, 3) != 0) ? scrt_pkg::ACT_RESERVE
                                                   : scrt_pkg::ACT_QUERY;
      w.resource_kind = 2'($urandom_range(0, 2));
      w.resource_id   = ($urandom_range(0, 3) != 0) ? 6'(hot_base + $urandom_range(0, 3))
                                                   : 6'($urandom_range(0, 63));
      if (w.resource_kind == scrt_pkg::KIND_SECTOR)
         w.time_req = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 255))
                                                  : 12'($urandom_range(0, 3));
      else
         w.time_req = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 480))
                                                  : 12'($urandom_range(0, 45));
      w.capacity      = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 5))
                                                   : 8'($urandom_range(0, 255));
      return w;
   endfunction

   // Offer one word at the falling edge and hold it until the block takes it.
   // An optional idle burst comes first; push drops only for that burst.
   task automatic send_word(input scrt_pkg::req_type w, input bit typed,
                            input scrt_pkg::rsp_type want);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         push = 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
      push      = 1'b1;
      req_word  = w;
      req_typed = typed;
      req_want  = want;
      do @(posedge clock); while (full);
      @(negedge clock);
   endtask

   // Result side: pop at the falling edge, with stall bursts while idling is on.
   always @(negedge clock) begin
      if (reset) begin
         pop = 1'b0;
      end else if (pop_hold > 0) begin
         pop      = 1'b0;
         pop_hold = pop_hold - 1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         pop      = 1'b0;
         pop_hold = $urandom_range(0, 17);
      end else begin
         pop = 1'b1;
      end
   end

   // Sample both handshakes at the rising edge: check a popped word against
   // the oldest expectation, then predict for a pushed word.
   always @(posedge clock) begin : watch
      scrt_pkg::rsp_type want;
      scrt_pkg::rsp_type predicted;
      if (!reset) begin
         if (pop && !empty) begin
            if (answers_due.size() == 0) begin
               $display("%0t: unexpected result word %p", $time, rsp_word);
               errors++;
            end else begin
               want = answers_due.pop_front();
               if (rsp_word.at_capacity !== want.at_capacity) begin
                  $display("%0t: at_capacity expected %0d actual %0d",
                           $time, want.at_capacity, rsp_word.at_capacity);
                  errors++;
               end
               if (rsp_word.remaining !== want.remaining) begin
                  $display("%0t: remaining expected %0d actual %0d",
                           $time, want.remaining, rsp_word.remaining);
                  errors++;
               end
               if (rsp_word.status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, rsp_word.status);
                  errors++;
               end
            end
         end
         if (push && !full) begin
            // Advance the predictor even when the answer is typed in.
            predicted = book_slot(req_word);
            answers_due.push_back(req_typed ? req_want : predicted);
         end
      end
   end

   initial begin
      stim_row_type plan [0:23];
      int           n;
      plan = '{
         // Capacity 0 latched: full everywhere, a reserve is refused.
         entry(scrt_pkg::ACT_QUERY,   scrt_pkg::KIND_SECTOR,    0,    0,   0,
               1, 1,   0, scrt_pkg::STATUS_OK),
         entry(scrt_pkg::ACT_RESERVE, scrt_pkg::KIND_SECTOR,    0,    5, 200,
               1, 1,   0, scrt_pkg::STATUS_REFUSE),
         // Largest capacity on the last sector and last slot.
         entry(scrt_pkg::ACT_RESERVE, scrt_pkg::KIND_SECTOR,   63,  255, 255,
               1, 0, 254, scrt_pkg::STATUS_OK),
         entry(scrt_pkg::ACT_QUERY,   scrt_pkg::KIND_SECTOR,   63,  255,   3,
               1, 0, 254, scrt_pkg::STATUS_OK),
         // Times past the sector table and the unused kind.
         entry(scrt_pkg::ACT_QUERY,   scrt_pkg::KIND_SECTOR,   63,  256, 255,
               1, 0,   0, scrt_pkg::STATUS_RANGE),
         entry(scrt_pkg::ACT_RESERVE, scrt_pkg::KIND_SECTOR,    1, 4095, 255,
               1, 0,   0, scrt_pkg::STATUS_RANGE),
         entry(scrt_pkg::ACT_RESERVE, KIND_UNUSED,              5,   10,   9,
               1, 0,   0, scrt_pkg::STATUS_RANGE),
         // Arrival bins: time 0 and 15 share bin 0, 480 is the last bin.
         entry(scrt_pkg::ACT_RESERVE, scrt_pkg::KIND_ARRIVAL,   2,    0,   1,
               1, 0,   0, scrt_pkg::STATUS_OK),
         entry(scrt_pkg::ACT_RESERVE, scrt_pkg::KIND_ARRIVAL,   2,   15,   9,
               1, 1,   0, scrt_pkg::STATUS_REFUSE),
         entry(scrt_pkg::ACT_QUERY,   scrt_pkg::KIND_ARRIVAL,   2,   16,   9,
               1, 0,   1, scrt_pkg::STATUS_OK),
         entry(scrt_pkg::ACT_RESERVE, scrt_pkg::KIND_ARRIVAL,   2,  480,   9,
               1, 0,   0, scrt_pkg::STATUS_OK),
         entry(scrt_pkg::ACT_RESERVE, scrt_pkg::KIND_ARRIVAL,   2,  481,   9,
               1, 0,   0, scrt_pkg::STATUS_RANGE),
         // Departures keep their own capacity and counters.
         entry(scrt_pkg::ACT_RESERVE, scrt_pkg::KIND_DEPARTURE, 2,    1,   2,
               1, 0,   1, scrt_pkg::STATUS_OK),
         entry(scrt_pkg::ACT_RESERVE, scrt_pkg::KIND_DEPARTURE, 2,    1,   0,
               1, 0,   0, scrt_pkg::STATUS_OK),
         entry(scrt_pkg::ACT_QUERY,   scrt_pkg::KIND_DEPARTURE, 2,   15,   0,
               1, 1,   0, scrt_pkg::STATUS_OK),
         // A range error latches nothing; the next good touch does.
         entry(scrt_pkg::ACT_RESERVE, scrt_pkg::KIND_DEPARTURE, 63, 4095, 128,
               1, 0,   0, scrt_pkg::STATUS_RANGE),
         entry(scrt_pkg::ACT_RESERVE, scrt_pkg::KIND_DEPARTURE, 63,   30, 128,
               1, 0, 127, scrt_pkg::STATUS_OK),
         entry(scrt_pkg::ACT_QUERY,   scrt_pkg::KIND_SECTOR,   42,  170, 8'hAA),
         entry(scrt_pkg::ACT_RESERVE, scrt_pkg::KIND_SECTOR,   21,   85, 8'h55),
         // Back-to-back reserves on one slot until it refuses.
         entry(scrt_pkg::ACT_RESERVE, scrt_pkg::KIND_SECTOR,    7,    3,   2),
         entry(scrt_pkg::ACT_RESERVE, scrt_pkg::KIND_SECTOR,    7,    3,   2),
         entry(scrt_pkg::ACT_RESERVE, scrt_pkg::KIND_SECTOR,    7,    3,   2),
         entry(scrt_pkg::ACT_QUERY,   scrt_pkg::KIND_SECTOR,    7,    3,   2),
         entry(scrt_pkg::ACT_QUERY,   scrt_pkg::KIND_ARRIVAL,  63, 4095, 255,
               1, 0,   0, scrt_pkg::STATUS_RANGE)
      };

      // Hold reset, then release it at a falling edge; the block's clearing
      // pass keeps full high for a while, which send_word simply waits out.
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (plan[i]) send_word(plan[i].word, plan[i].typed, plan[i].want);

      // Random traffic: idle on both sides, then a quiet stretch, then idle
      // again, and a final stretch with none. Move the hot set now and then.
      for (n = 0; n < 900; n++) begin
         idle_on = (n < 350) || (n >= 550 && n < 800);
         if (n % 150 == 0) hot_base = $urandom_range(0, 15) * 4;
         send_word(random_word(), 1'b0, '0);
      end
      push = 1'b0;

      // Drain every outstanding result, then let the pipeline settle.
      while (answers_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // Guard against a hang: clearing pass plus every word at its worst gaps
   // and stalls, taken many times over.
   initial begin
      #5000000;
      $display("simulation failed");
      $finish;
   end

endmodule

// File: files.f
hdl/scrt_pkg.sv
hdl/scrt_front.sv
hdl/scrt_cmd_queue.sv
hdl/scrt_back.sv
hdl/slot_capacity_reservation_table_top.sv
dv/slot_capacity_reservation_table_top_tb.sv
